// ----- src/irnb_pkg.sv -----
// ----------------------------------------------------------------------------
// irnb_pkg
// Shared types and codes for the nearest / bilinear image scaler.
// ----------------------------------------------------------------------------
package irnb_pkg;

  // configuration register field widths, fixed by the register map
  localparam int SRC_DIM_BITS = 9;
  localparam int DST_DIM_BITS = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COORD_BITS = 12;
  localparam int RATIO_BITS = 24;
  localparam int FRAC_BITS = 16;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_SCALE_MODE = 3'd4
  } cfg_index_t;

  // request action codes
  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_PRODUCE = 1'b1
  } action_t;

  // scale mode codes
  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } scale_mode_t;

  // input request payload
  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            in_red;
    logic [7:0]            in_green;
    logic [7:0]            in_blue;
    logic [7:0]            in_alpha;
  } in_t;

  // result payload
  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic [7:0]            out_alpha;
    logic                  out_of_range;
  } out_t;

  // image dimensions handed to the ratio divider
  typedef struct packed {
    logic [SRC_DIM_BITS-1:0] src_width;
    logic [SRC_DIM_BITS-1:0] src_height;
    logic [DST_DIM_BITS-1:0] dst_width;
    logic [DST_DIM_BITS-1:0] dst_height;
  } dims_t;

endpackage

// ----- src/image_resize_nearest_bilinear.sv -----
// throughput: one request per cycle but for output stalls and ratio divides;
// four frame store banks split by pixel parity read all four neighbors at once
// a size register write blocks requests and writes through start_r and the
// one-bit-a-cycle ratio divide of both axes; a mode write blocks nothing
// reset: synchronous active low; the same ratio divide follows reset
// ----------------------------------------------------------------------------
// image_resize_nearest_bilinear
// Six-stage scaler pipeline: request register, multiply, neighbor select,
// banked read, horizontal blend, vertical blend into the output register.
// ----------------------------------------------------------------------------
module image_resize_nearest_bilinear #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096,
  parameter int WEIGHT_BITS    = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  irnb_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output irnb_pkg::out_t                        out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [irnb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [irnb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import irnb_pkg::*;

  localparam int SRC_W_CAP  = MAX_SRC_WIDTH > 511 ? 511 : MAX_SRC_WIDTH;
  localparam int SRC_H_CAP  = MAX_SRC_HEIGHT > 511 ? 511 : MAX_SRC_HEIGHT;
  localparam int DST_CAP    = MAX_DST_DIM > 8191 ? 8191 : MAX_DST_DIM;
  localparam int SRC_W_RST  = MAX_SRC_WIDTH < 256 ? MAX_SRC_WIDTH : 256;
  localparam int SRC_H_RST  = MAX_SRC_HEIGHT < 256 ? MAX_SRC_HEIGHT : 256;
  localparam int DST_RST    = MAX_DST_DIM < 256 ? MAX_DST_DIM : 256;
  localparam int COL_BITS   = MAX_SRC_WIDTH > 2 ? $clog2(MAX_SRC_WIDTH) : 2;
  localparam int ROW_BITS   = MAX_SRC_HEIGHT > 2 ? $clog2(MAX_SRC_HEIGHT) : 2;
  localparam int ADDR_BITS  = COL_BITS + ROW_BITS - 2;
  localparam int BANK_DEPTH = 1 << ADDR_BITS;
  localparam int PROD_BITS  = COORD_BITS + RATIO_BITS;
  localparam int INT_BITS   = PROD_BITS - FRAC_BITS;
  localparam int WB         = WEIGHT_BITS;
  localparam int WEIGHT_ONE = 1 << WEIGHT_BITS;

  typedef logic [3:0][7:0] rgba_t;

  // blend of two channels with a fractional weight, truncated
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [WB-1:0] w);
    logic [WB:0]   wc;
    logic [WB+8:0] s;
    wc = (WB+1)'(WEIGHT_ONE) - {1'b0, w};
    s  = (WB+9)'(a) * (WB+9)'(wc) + (WB+9)'(b) * (WB+9)'(w);
    return s[WB +: 8];
  endfunction

  // configuration registers
  logic [SRC_DIM_BITS-1:0] src_width_r, src_height_r;
  logic [DST_DIM_BITS-1:0] dst_width_r, dst_height_r;
  logic                    scale_mode_r;
  logic                    start_r;
  logic                    ratio_busy;
  logic [RATIO_BITS-1:0]   ratio_h, ratio_v;
  logic                    cfg_fire;
  logic                    dim_write;
  logic [SRC_DIM_BITS-1:0] cfg_src;
  logic [DST_DIM_BITS-1:0] cfg_dst;
  logic [SRC_DIM_BITS-1:0] src_w_clamped, src_h_clamped;
  logic [DST_DIM_BITS-1:0] dst_clamped;
  dims_t                   dims;

  // pipeline control
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv && !ratio_busy && !start_r;
  assign cfg_ready = !ratio_busy && !start_r;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // size registers restart the ratio divide
  assign dim_write = cfg_index == CFG_SRC_WIDTH || cfg_index == CFG_SRC_HEIGHT ||
                     cfg_index == CFG_DST_WIDTH || cfg_index == CFG_DST_HEIGHT;

  // register value clamping
  always_comb begin
    cfg_src = cfg_data[SRC_DIM_BITS-1:0];
    cfg_dst = cfg_data[DST_DIM_BITS-1:0];
    if (cfg_src == '0) begin
      src_w_clamped = SRC_DIM_BITS'(1);
      src_h_clamped = SRC_DIM_BITS'(1);
    end else begin
      src_w_clamped = 32'(cfg_src) > SRC_W_CAP ? SRC_DIM_BITS'(SRC_W_CAP) : cfg_src;
      src_h_clamped = 32'(cfg_src) > SRC_H_CAP ? SRC_DIM_BITS'(SRC_H_CAP) : cfg_src;
    end
    if (cfg_dst == '0) begin
      dst_clamped = DST_DIM_BITS'(1);
    end else begin
      dst_clamped = 32'(cfg_dst) > DST_CAP ? DST_DIM_BITS'(DST_CAP) : cfg_dst;
    end
  end

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_DIM_BITS'(SRC_W_RST);
      src_height_r <= SRC_DIM_BITS'(SRC_H_RST);
      dst_width_r  <= DST_DIM_BITS'(DST_RST);
      dst_height_r <= DST_DIM_BITS'(DST_RST);
      scale_mode_r <= MODE_NEAREST;
      start_r      <= 1'b1;
    end else begin
      start_r <= cfg_fire && dim_write;
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_SRC_WIDTH: begin
            src_width_r <= src_w_clamped;
          end
          CFG_SRC_HEIGHT: begin
            src_height_r <= src_h_clamped;
          end
          CFG_DST_WIDTH: begin
            dst_width_r <= dst_clamped;
          end
          CFG_DST_HEIGHT: begin
            dst_height_r <= dst_clamped;
          end
          CFG_SCALE_MODE: begin
            scale_mode_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign dims = '{src_width: src_width_r, src_height: src_height_r,
                  dst_width: dst_width_r, dst_height: dst_height_r};

  irnb_ratio u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .dims    (dims),
    .ratio_h (ratio_h),
    .ratio_v (ratio_v),
    .busy    (ratio_busy)
  );

  // stage 1: request register
  in_t s1_item_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_data;
    end
  end

  // stage 2: source position products and range check
  in_t                  s2_item_r;
  logic [PROD_BITS-1:0] s2_px_r, s2_py_r;
  logic                 s2_oor_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r <= s1_item_r;
      s2_px_r   <= PROD_BITS'(s1_item_r.pixel_x) * PROD_BITS'(ratio_h);
      s2_py_r   <= PROD_BITS'(s1_item_r.pixel_y) * PROD_BITS'(ratio_v);
      s2_oor_r  <= {1'b0, s1_item_r.pixel_x} >= dst_width_r ||
                   {1'b0, s1_item_r.pixel_y} >= dst_height_r;
    end
  end

  // stage 3: clamped neighbors, weights and bank addresses
  logic [INT_BITS-1:0]     ix, iy;
  logic [SRC_DIM_BITS-1:0] sw_m1, sh_m1;
  logic [COL_BITS-1:0]     col_l, col_r, col_sel;
  logic [ROW_BITS-1:0]     row_t, row_b, row_sel;
  logic [3:0][ADDR_BITS-1:0] raddr;
  logic                    load_ok;

  always_comb begin
    ix    = s2_px_r[PROD_BITS-1:FRAC_BITS];
    iy    = s2_py_r[PROD_BITS-1:FRAC_BITS];
    sw_m1 = src_width_r - 1'b1;
    sh_m1 = src_height_r - 1'b1;
    col_l = ix > INT_BITS'(sw_m1) ? COL_BITS'(sw_m1) : COL_BITS'(ix);
    row_t = iy > INT_BITS'(sh_m1) ? ROW_BITS'(sh_m1) : ROW_BITS'(iy);
    col_r = col_l == COL_BITS'(sw_m1) ? col_l : col_l + 1'b1;
    row_b = row_t == ROW_BITS'(sh_m1) ? row_t : row_t + 1'b1;
    col_sel = '0;
    row_sel = '0;
    for (int k = 0; k < 4; k++) begin
      col_sel  = col_l[0] == k[0] ? col_l : col_r;
      row_sel  = row_t[0] == k[1] ? row_t : row_b;
      raddr[k] = {row_sel[ROW_BITS-1:1], col_sel[COL_BITS-1:1]};
    end
    load_ok = 32'(s2_item_r.pixel_x) < MAX_SRC_WIDTH &&
              32'(s2_item_r.pixel_y) < MAX_SRC_HEIGHT;
  end

  in_t                       s3_item_r;
  logic                      s3_oor_r;
  logic [3:0][ADDR_BITS-1:0] s3_raddr_r;
  logic [3:0]                s3_par_r;
  logic [WB-1:0]             s3_wx_r, s3_wy_r;
  logic                      s3_we_r;
  logic [1:0]                s3_wbank_r;
  logic [ADDR_BITS-1:0]      s3_waddr_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item_r  <= s2_item_r;
      s3_oor_r   <= s2_oor_r;
      s3_raddr_r <= raddr;
      // parity of left, right, top, bottom
      s3_par_r   <= {col_l[0], col_r[0], row_t[0], row_b[0]};
      s3_wx_r    <= s2_px_r[FRAC_BITS-1 -: WB];
      s3_wy_r    <= s2_py_r[FRAC_BITS-1 -: WB];
      s3_we_r    <= v2_r && s2_item_r.action == ACT_LOAD && load_ok;
      s3_wbank_r <= {s2_item_r.pixel_y[0], s2_item_r.pixel_x[0]};
      s3_waddr_r <= {s2_item_r.pixel_y[ROW_BITS-1:1], s2_item_r.pixel_x[COL_BITS-1:1]};
    end
  end

  // stage 4: banked frame store, bank index is {row parity, column parity}
  rgba_t s4_rd [4];
  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [31:0] mem [BANK_DEPTH];
    rgba_t       rd_r;
    always_ff @(posedge clk) begin
      if (adv && s3_we_r && s3_wbank_r == 2'(g)) begin
        mem[s3_waddr_r] <= {s3_item_r.in_red, s3_item_r.in_green,
                            s3_item_r.in_blue, s3_item_r.in_alpha};
      end
      if (adv && v3_r) begin
        rd_r <= mem[s3_raddr_r[g]];
      end
    end
    assign s4_rd[g] = rd_r;
  end

  in_t           s4_item_r;
  logic          s4_oor_r;
  logic [3:0]    s4_par_r;
  logic [WB-1:0] s4_wx_r, s4_wy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_item_r <= s3_item_r;
      s4_oor_r  <= s3_oor_r;
      s4_par_r  <= s3_par_r;
      s4_wx_r   <= s3_wx_r;
      s4_wy_r   <= s3_wy_r;
    end
  end

  // stage 5: neighbor select and horizontal blend (top-left only in nearest mode)
  rgba_t p_lt, p_rt, p_lb, p_rb, top, bot;
  always_comb begin
    p_lt = s4_rd[{s4_par_r[1], s4_par_r[3]}];
    p_rt = s4_rd[{s4_par_r[1], s4_par_r[2]}];
    p_lb = s4_rd[{s4_par_r[0], s4_par_r[3]}];
    p_rb = s4_rd[{s4_par_r[0], s4_par_r[2]}];
    for (int c = 0; c < 4; c++) begin
      if (scale_mode_r == MODE_NEAREST) begin
        top[c] = p_lt[c];
        bot[c] = p_lt[c];
      end else begin
        top[c] = blend(p_lt[c], p_rt[c], s4_wx_r);
        bot[c] = blend(p_lb[c], p_rb[c], s4_wx_r);
      end
    end
  end

  in_t           s5_item_r;
  logic          s5_oor_r;
  rgba_t         s5_top_r, s5_bot_r;
  logic [WB-1:0] s5_wy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_item_r <= s4_item_r;
      s5_oor_r  <= s4_oor_r;
      s5_top_r  <= top;
      s5_bot_r  <= bot;
      s5_wy_r   <= s4_wy_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid && in_ready;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r && s5_item_r.action == ACT_PRODUCE;
    end
  end

  // stage 6: vertical blend into the output register
  rgba_t vert;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vert[c] = s5_oor_r ? 8'd0 : blend(s5_top_r[c], s5_bot_r[c], s5_wy_r);
    end
  end

  out_t out_data_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= '{out_x: s5_item_r.pixel_x, out_y: s5_item_r.pixel_y,
                      out_red: vert[3], out_green: vert[2], out_blue: vert[1],
                      out_alpha: vert[0], out_of_range: s5_oor_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // nothing is accepted while ratios are recomputed
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_busy |-> !in_ready && !cfg_ready)
    else $error("request accepted during ratio divide");

  // out of range results carry zero color
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |->
      out_data.out_red == 8'd0 && out_data.out_green == 8'd0 &&
      out_data.out_blue == 8'd0 && out_data.out_alpha == 8'd0)
    else $error("out of range result with nonzero color");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v5_r && s5_item_r.action == ACT_LOAD |=> !out_valid)
    else $error("load request produced a result");

  // a stalled pipeline holds the frame store write enable and address stable
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s3_we_r) && $stable(s3_waddr_r))
    else $error("write stage changed during stall");
`endif

endmodule

// ----- src/irnb_ratio.sv -----
// ----------------------------------------------------------------------------
// irnb_ratio
// Radix-2 restoring divider computing both 8.16 scale ratios, one quotient
// bit per cycle, horizontal axis first and then vertical.
// ----------------------------------------------------------------------------
module irnb_ratio (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  irnb_pkg::dims_t                      dims,
  output logic [irnb_pkg::RATIO_BITS-1:0]      ratio_h,
  output logic [irnb_pkg::RATIO_BITS-1:0]      ratio_v,
  output logic                                 busy
);
  import irnb_pkg::*;

  localparam int QUO_BITS = SRC_DIM_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(QUO_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HORZ = 3'b010,
    ST_VERT = 3'b100
  } div_state_t;

  div_state_t                state_r, state_nxt;
  logic [QUO_BITS-1:0]       quo_r, quo_nxt;
  logic [DST_DIM_BITS-1:0]   rem_r, rem_nxt;
  logic [CNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic [RATIO_BITS-1:0]     ratio_h_r, ratio_h_nxt;
  logic [RATIO_BITS-1:0]     ratio_v_r, ratio_v_nxt;

  logic [DST_DIM_BITS-1:0]   divisor;
  logic [DST_DIM_BITS:0]     trial;
  logic                      ge;
  logic [QUO_BITS-1:0]       step_quo;
  logic [DST_DIM_BITS-1:0]   step_rem;
  logic [RATIO_BITS-1:0]     sat_quo;
  logic                      last_step;

  // one restoring step
  always_comb begin
    divisor   = state_r == ST_VERT ? dims.dst_height : dims.dst_width;
    trial     = {rem_r, quo_r[QUO_BITS-1]};
    ge        = trial >= {1'b0, divisor};
    step_rem  = ge ? DST_DIM_BITS'(trial - {1'b0, divisor}) : trial[DST_DIM_BITS-1:0];
    step_quo  = {quo_r[QUO_BITS-2:0], ge};
    sat_quo   = step_quo[QUO_BITS-1:RATIO_BITS] != '0 ? '1 : step_quo[RATIO_BITS-1:0];
    last_step = cnt_r == CNT_BITS'(QUO_BITS - 1);
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    ratio_h_nxt = ratio_h_r;
    ratio_v_nxt = ratio_v_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          quo_nxt   = {dims.src_width, {FRAC_BITS{1'b0}}};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_HORZ;
        end
      end
      ST_HORZ: begin
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          ratio_h_nxt = sat_quo;
          quo_nxt     = {dims.src_height, {FRAC_BITS{1'b0}}};
          rem_nxt     = '0;
          cnt_nxt     = '0;
          state_nxt   = ST_VERT;
        end
      end
      ST_VERT: begin
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          ratio_v_nxt = sat_quo;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    ratio_h_r <= ratio_h_nxt;
    ratio_v_r <= ratio_v_nxt;
  end

  assign ratio_h = ratio_h_r;
  assign ratio_v = ratio_v_r;
  assign busy    = state_r != ST_IDLE;

endmodule

// ----- verif/image_resize_nearest_bilinear_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_resize_nearest_bilinear_tb
// Loads a source frame and scales it, then checks every produced pixel
// against a scaler model kept in the bench, across sizes and both modes.
// ----------------------------------------------------------------------------
module image_resize_nearest_bilinear_tb;
  import irnb_pkg::*;

  localparam int SRC_MAX = 256;
  localparam int DST_MAX = 4096;
  localparam int WBITS = 8;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // scaler model state
  logic [31:0] pixel_mem [0:SRC_MAX*SRC_MAX-1];
  bit pixel_loaded [0:SRC_MAX*SRC_MAX-1];
  int unsigned src_w, src_h, dst_w, dst_h;
  scale_mode_t mode;
  logic [23:0] ratio_h, ratio_v;

  out_t pending_pixels [$];
  int mismatches = 0;
  int pixels_checked = 0;
  int requests_sent = 0;
  int idle_cycles = 0;
  int ready_hold = 0;
  bit timed_out = 1'b0;

  image_resize_nearest_bilinear u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [23:0] scale_ratio(int unsigned s, int unsigned d);
    longint unsigned r;
    r = (longint'(s) << 16) / d;
    return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
  endfunction

  function automatic int unsigned mix(int unsigned a, int unsigned b, int unsigned w);
    return (a * ((1 << WBITS) - w) + b * w) >> WBITS;
  endfunction

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] chan(logic [31:0] p, int c);
    return p[31-8*c -: 8];
  endfunction

  // expected pixel for a produce request
  function automatic out_t scaled_pixel(in_t req);
    out_t r;
    longint unsigned px, py;
    int unsigned l, t, rr, bb, wx, wy, top, bot;
    r = '0;
    r.out_x = req.pixel_x;
    r.out_y = req.pixel_y;
    r.out_of_range = (req.pixel_x >= dst_w) || (req.pixel_y >= dst_h);
    if (r.out_of_range) return r;
    px = longint'(req.pixel_x) * ratio_h;
    py = longint'(req.pixel_y) * ratio_v;
    l = min_u(32'(px >> 16), src_w - 1);
    t = min_u(32'(py >> 16), src_h - 1);
    wx = 32'(px[15:16-WBITS]);
    wy = 32'(py[15:16-WBITS]);
    rr = min_u(l + 1, src_w - 1);
    bb = min_u(t + 1, src_h - 1);
    for (int c = 0; c < 4; c++) begin
      if (mode == MODE_NEAREST) begin
        top = chan(pixel_mem[t*SRC_MAX+l], c);
      end else begin
        top = mix(chan(pixel_mem[t*SRC_MAX+l], c), chan(pixel_mem[t*SRC_MAX+rr], c), wx);
        bot = mix(chan(pixel_mem[bb*SRC_MAX+l], c), chan(pixel_mem[bb*SRC_MAX+rr], c), wx);
        top = mix(top, bot, wy);
      end
      case (c)
        0: r.out_red = 8'(top);
        1: r.out_green = 8'(top);
        2: r.out_blue = 8'(top);
        default: r.out_alpha = 8'(top);
      endcase
    end
    return r;
  endfunction

  // idle cycles between requests, mostly short, now and then long
  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // send one request, update the model at acceptance
  task automatic send_request(in_t req);
    int n;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (req.action == ACT_LOAD) begin
      if (req.pixel_x < SRC_MAX && req.pixel_y < SRC_MAX) begin
        pixel_mem[req.pixel_y*SRC_MAX+req.pixel_x] =
          {req.in_red, req.in_green, req.in_blue, req.in_alpha};
        pixel_loaded[req.pixel_y*SRC_MAX+req.pixel_x] = 1'b1;
      end
    end else begin
      pending_pixels.push_back(scaled_pixel(req));
    end
    @(negedge clk);
    // with no gap, valid stays high for the next request
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic load_pixel(int x, int y);
    in_t req;
    req = '0;
    req.action = ACT_LOAD;
    req.pixel_x = COORD_BITS'(x);
    req.pixel_y = COORD_BITS'(y);
    {req.in_red, req.in_green, req.in_blue, req.in_alpha} = $urandom();
    send_request(req);
  endtask

  task automatic produce_pixel(int x, int y);
    in_t req;
    req = '0;
    req.action = ACT_PRODUCE;
    req.pixel_x = COORD_BITS'(x);
    req.pixel_y = COORD_BITS'(y);
    {req.in_red, req.in_green, req.in_blue, req.in_alpha} = $urandom();
    send_request(req);
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SRC_WIDTH:  src_w = clamp_size(value & 9'h1FF, SRC_MAX);
      CFG_SRC_HEIGHT: src_h = clamp_size(value & 9'h1FF, SRC_MAX);
      CFG_DST_WIDTH:  dst_w = clamp_size(value & 13'h1FFF, DST_MAX);
      CFG_DST_HEIGHT: dst_h = clamp_size(value & 13'h1FFF, DST_MAX);
      CFG_SCALE_MODE: mode = scale_mode_t'(value & 1);
      default: ;
    endcase
    ratio_h = scale_ratio(src_w, dst_w);
    ratio_v = scale_ratio(src_h, dst_h);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for all pixels out and the pipeline drained before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh, scale_mode_t m);
    drain();
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_SCALE_MODE, m);
  endtask

  // produce mostly inside the destination, now and then outside it
  task automatic produce_random(int n);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        if (x < dst_w && y < dst_h) x = dst_w + (x % (4096 - dst_w + 1));
        if (x > 4095) begin x = 0; y = dst_h; end
        if (y > 4095) begin x = dst_w; y = 0; end
      end else begin
        x = $urandom_range(0, dst_w - 1);
        y = $urandom_range(0, dst_h - 1);
      end
      produce_pixel(x, y);
    end
  endtask

  // every entry the produce requests can reach is loaded first
  task automatic test_full_frame_load();
    for (int y = 0; y < 16; y++)
      for (int x = 0; x < 16; x++)
        load_pixel(x, y);
  endtask

  task automatic test_directed();
    in_t req;
    set_sizes(16, 16, 4096, 4096, MODE_NEAREST);
    produce_pixel(0, 0);
    produce_pixel(4095, 4095);
    produce_pixel(4095, 0);
    set_sizes(16, 16, 7, 5, MODE_BILINEAR);
    produce_pixel(0, 0);
    produce_pixel(6, 4);
    produce_pixel(7, 0);
    produce_pixel(0, 5);
    produce_pixel(3, 2);
    // loads outside the store, plus a max-value load
    load_pixel(4095, 0);
    load_pixel(0, 4095);
    load_pixel(256, 255);
    req = '0;
    req.action = ACT_LOAD;
    req.pixel_x = 15;
    req.pixel_y = 15;
    {req.in_red, req.in_green, req.in_blue, req.in_alpha} = '1;
    send_request(req);
    produce_pixel(6, 4);
    // unknown register index and out-of-range sizes
    drain();
    write_reg(cfg_index_t'(3'd7), 13'h1FFF);
    write_reg(cfg_index_t'(3'd5), 0);
    write_reg(CFG_SRC_WIDTH, 0);
    write_reg(CFG_SRC_HEIGHT, 9'h1FF);
    write_reg(CFG_DST_WIDTH, 13'h1FFF);
    write_reg(CFG_DST_HEIGHT, 0);
    produce_pixel(100, 0);
    produce_pixel(0, 1);
    // shrink with src upper bound clamped onto loaded rows only
    set_sizes(16, 16, 1, 1, MODE_BILINEAR);
    produce_pixel(0, 0);
  endtask

  task automatic test_random_frames();
    int sw, sh;
    for (int phase = 0; phase < 8; phase++) begin
      sw = (phase == 0) ? 1 : (phase == 1) ? 256 : $urandom_range(1, 24);
      sh = (phase == 2) ? 1 : (phase == 1) ? 256 : $urandom_range(1, 24);
      if (phase == 1) begin
        drain();
        write_reg(CFG_SRC_WIDTH, 256);
        write_reg(CFG_SRC_HEIGHT, 256);
        write_reg(CFG_DST_WIDTH, 4);
        write_reg(CFG_DST_HEIGHT, 4);
        write_reg(CFG_SCALE_MODE, MODE_NEAREST);
        // nearest picks only multiples of 64
        for (int y = 0; y < 4; y++)
          for (int x = 0; x < 4; x++)
            load_pixel(x*64, y*64);
        produce_random(16);
        continue;
      end
      set_sizes(sw, sh, $urandom_range(1, (phase == 3) ? 4096 : 40),
                $urandom_range(1, (phase == 4) ? 4096 : 40), scale_mode_t'(phase & 1));
      for (int y = 0; y < sh; y++)
        for (int x = 0; x < sw; x++)
          if (!pixel_loaded[y*SRC_MAX+x] || $urandom_range(0, 3) == 0) load_pixel(x, y);
      produce_random(30);
      // a few stray loads and reloads mixed with produce requests
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(0, 1)) load_pixel($urandom_range(0, sw - 1), $urandom_range(0, sh - 1));
        else load_pixel($urandom_range(256, 4095), $urandom_range(0, 4095));
        produce_random(2);
      end
    end
  endtask

  // result checker with random back-pressure
  always @(posedge clk) begin
    out_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %p", out_data);
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_data !== exp_px) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch at (%0d,%0d): expected %p, got %p",
                     exp_px.out_x, exp_px.out_y, exp_px, out_data);
        end
      end
    end
  end

  // output ready: mostly high, short random drops and an occasional long stall
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (r == 0) begin
      ready_hold = $urandom_range(10, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= (r < 75) || ($urandom_range(0, 9) == 0);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SRC_MAX*SRC_MAX; i++) begin
      pixel_mem[i] = '0;
      pixel_loaded[i] = 1'b0;
    end
    src_w = 256; src_h = 256; dst_w = 256; dst_h = 256;
    mode = MODE_NEAREST;
    ratio_h = 24'h010000; ratio_v = 24'h010000;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_full_frame_load();
    test_directed();
    test_random_frames();
    drain();
    $display("sent %0d requests, checked %0d pixels across nearest and bilinear frames",
             requests_sent, pixels_checked);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/irnb_pkg.sv
src/irnb_ratio.sv
src/image_resize_nearest_bilinear.sv
verif/image_resize_nearest_bilinear_tb.sv
